// File: rtl/vdm_pkg.sv
// ----------------------------------------------------------------------------
// vdm_pkg
// Shared types, codes and constants of the vector distance metric engine.
// ----------------------------------------------------------------------------
`default_nettype none

package vdm_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int CNT_W       = 17;   // holds any element count up to 131071
  localparam int MODE_W      = 3;
  localparam int METRIC_W    = 48;
  localparam int STATUS_W    = 2;

  localparam logic [MODE_W-1:0] MODE_EUCLID    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEARSON   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MANHATTAN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COSINE    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET     = MODE_EUCLID;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MODE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

  localparam logic [METRIC_W-1:0] MET_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [METRIC_W-1:0] MET_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [METRIC_W-1:0] metric;
    logic [STATUS_W-1:0]        status;
  } out_item_t;

  // Sums of one finished vector, all widened to 64 bits
  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [63:0]       sx;
    logic [63:0]       sy;
    logic [63:0]       sxy;
    logic [63:0]       sx2;
    logic [63:0]       sy2;
    logic [63:0]       sd2;
    logic [63:0]       sad;
    logic [MODE_W-1:0] mode;
    logic              too_long;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/vector_distance_metric_engine_unit.sv
// ----------------------------------------------------------------------------
// vector_distance_metric_engine_unit
// Streams element pairs of two vectors and returns one distance or
// similarity metric per vector.
//
// Input queue: write an item (x, y, last) with push while full is low, one
// per cycle. Pairs are summed in a two-stage front end; the last pair hands
// the vector's sums to a two-entry job queue, so the next vector streams in
// while the previous one is still being worked on.
// Result queue: while empty is low, result holds the oldest metric; pop
// takes it. One result per vector, in order.
// Euclidean and Manhattan come straight from the sums; Pearson runs
// seven products on one shared 32x32 multiplier, then a root and a
// divide; cosine runs one product, then the root and the divide.
// full rises only when a last pair waits while both job queue entries
// are taken; a result not popped holds the sequencer in its final step.
// cfg_data selects the metric (reset: squared Euclidean); cfg_ready is
// always high. Reset empties both queues and clears the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_distance_metric_engine_unit
  import vdm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire in_item_t          item,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output out_item_t              result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [MODE_W-1:0] cfg_data
);

  logic [MODE_W-1:0] mode;
  logic              job_push;
  job_t              job_in;
  logic              job_pop;
  job_t              q_mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        q_count;
  logic              q_full;
  logic              q_valid;
  logic              res_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  vdm_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .mode    (mode),
    .job_push(job_push),
    .job     (job_in),
    .job_full(q_full)
  );

  // job queue between front and sequencer
  assign q_full  = q_count == 2'd2;
  assign q_valid = q_count != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= '0;
    end else begin
      if (job_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= !rd_ptr;
      end
      q_count <= q_count + 2'(job_push) - 2'(job_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) begin
      q_mem[wr_ptr] <= job_in;
    end
  end

  vdm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(q_valid),
    .job      (q_mem[rd_ptr]),
    .job_pop  (job_pop),
    .res_valid(res_valid),
    .res      (result),
    .res_pop  (pop)
  );

  assign empty = !res_valid;

  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_count <= 2'd2)
    else $error("job queue overflow");

  a_full_only_when_queue_full: assert property (@(posedge clk) disable iff (rst)
    full |-> q_full)
    else $error("input stalled with room in the job queue");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result lost without a pop");

  a_no_push_on_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !job_push || job_pop)
    else $error("job written into a full queue");

endmodule

`default_nettype wire

// File: rtl/vdm_front.sv
// ----------------------------------------------------------------------------
// vdm_front
// Element products in one stage, running sums in the next; hands a finished
// vector's sums to the job queue on the last pair.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_front
  import vdm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire in_item_t          item,
  output logic                   full,
  input  wire logic [MODE_W-1:0] mode,
  output logic                   job_push,
  output job_t                   job,
  input  wire logic              job_full
);

  localparam int SW   = $clog2(MAX_LEN + 1);
  localparam int CW   = $clog2(MAX_LEN + 2);
  localparam int SXW  = 16 + SW;
  localparam int SXYW = 32 + SW;
  localparam int SQW  = 31 + SW;
  localparam int SDW  = 32 + SW;
  localparam int SAW  = 16 + SW;

  // product stage
  logic               s1_valid;
  logic               s1_last;
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_y;
  logic signed [31:0] s1_xy;
  logic [30:0]        s1_xx;
  logic [30:0]        s1_yy;
  logic [31:0]        s1_d2;
  logic [15:0]        s1_ad;

  logic signed [16:0] diff;
  logic signed [31:0] xx_full;
  logic signed [31:0] yy_full;
  logic signed [33:0] d2_full;
  logic signed [16:0] ad_full;

  // sums
  logic signed [SXW-1:0]  sx;
  logic signed [SXW-1:0]  sy;
  logic signed [SXYW-1:0] sxy;
  logic [SQW-1:0]         sx2;
  logic [SQW-1:0]         sy2;
  logic [SDW-1:0]         sd2;
  logic [SAW-1:0]         sad;
  logic [CW-1:0]          cnt;

  logic signed [SXW-1:0]  sx_upd;
  logic signed [SXW-1:0]  sy_upd;
  logic signed [SXYW-1:0] sxy_upd;
  logic [SQW-1:0]         sx2_upd;
  logic [SQW-1:0]         sy2_upd;
  logic [SDW-1:0]         sd2_upd;
  logic [SAW-1:0]         sad_upd;
  logic [CW-1:0]          cnt_upd;
  logic                   room;
  logic                   advance;
  logic                   acc_en;

  assign advance = !(s1_valid && s1_last && job_full);
  assign full    = !advance;
  assign acc_en  = s1_valid && advance;

  always_comb begin
    diff    = {item.x_value[15], item.x_value} - {item.y_value[15], item.y_value};
    xx_full = item.x_value * item.x_value;
    yy_full = item.y_value * item.y_value;
    d2_full = diff * diff;
    ad_full = diff[16] ? -diff : diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= push;
    end
    if (advance) begin
      s1_last <= item.last;
      s1_x    <= item.x_value;
      s1_y    <= item.y_value;
      s1_xy   <= item.x_value * item.y_value;
      s1_xx   <= xx_full[30:0];
      s1_yy   <= yy_full[30:0];
      s1_d2   <= d2_full[31:0];
      s1_ad   <= ad_full[15:0];
    end
  end

  always_comb begin
    room    = cnt < CW'(MAX_LEN);
    sx_upd  = sx;
    sy_upd  = sy;
    sxy_upd = sxy;
    sx2_upd = sx2;
    sy2_upd = sy2;
    sd2_upd = sd2;
    sad_upd = sad;
    cnt_upd = CW'(MAX_LEN + 1);   // pairs past the limit are dropped
    if (room) begin
      sx_upd  = sx + SXW'(s1_x);
      sy_upd  = sy + SXW'(s1_y);
      sxy_upd = sxy + SXYW'(s1_xy);
      sx2_upd = sx2 + SQW'(s1_xx);
      sy2_upd = sy2 + SQW'(s1_yy);
      sd2_upd = sd2 + SDW'(s1_d2);
      sad_upd = sad + SAW'(s1_ad);
      cnt_upd = cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sx  <= '0;
      sy  <= '0;
      sxy <= '0;
      sx2 <= '0;
      sy2 <= '0;
      sd2 <= '0;
      sad <= '0;
      cnt <= '0;
    end else if (acc_en) begin
      if (s1_last) begin
        sx  <= '0;
        sy  <= '0;
        sxy <= '0;
        sx2 <= '0;
        sy2 <= '0;
        sd2 <= '0;
        sad <= '0;
        cnt <= '0;
      end else begin
        sx  <= sx_upd;
        sy  <= sy_upd;
        sxy <= sxy_upd;
        sx2 <= sx2_upd;
        sy2 <= sy2_upd;
        sd2 <= sd2_upd;
        sad <= sad_upd;
        cnt <= cnt_upd;
      end
    end
  end

  assign job_push     = acc_en && s1_last;
  assign job.n        = CNT_W'(cnt_upd);
  assign job.sx       = 64'(sx_upd);
  assign job.sy       = 64'(sy_upd);
  assign job.sxy      = 64'(sxy_upd);
  assign job.sx2      = 64'(sx2_upd);
  assign job.sy2      = 64'(sy2_upd);
  assign job.sd2      = 64'(sd2_upd);
  assign job.sad      = 64'(sad_upd);
  assign job.mode     = mode;
  assign job.too_long = cnt_upd > CW'(MAX_LEN);

endmodule

`default_nettype wire

// File: rtl/vdm_mul.sv
// ----------------------------------------------------------------------------
// vdm_mul
// 64 x 64 -> 128 unsigned multiplier from four 32 x 32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_mul
  import vdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [127:0]     prod
);

  logic [63:0]  ar;
  logic [63:0]  br;
  logic         run;
  logic [2:0]   issue_k;
  logic         pp_valid;
  logic [1:0]   pp_k;
  logic [63:0]  pp;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [127:0] pp_shift;

  assign a_part = issue_k[0] ? ar[63:32] : ar[31:0];
  assign b_part = issue_k[1] ? br[63:32] : br[31:0];

  always_comb begin
    case (pp_k)
      2'd0:    pp_shift = {64'd0, pp};
      2'd1:    pp_shift = {32'd0, pp, 32'd0};
      2'd2:    pp_shift = {32'd0, pp, 32'd0};
      default: pp_shift = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      done     <= 1'b0;
      pp_valid <= 1'b0;
      issue_k  <= '0;
    end else begin
      if (start) begin
        run      <= 1'b1;
        done     <= 1'b0;
        issue_k  <= '0;
        pp_valid <= 1'b0;
      end else if (run) begin
        pp_valid <= !issue_k[2];
        if (!issue_k[2]) begin
          issue_k <= issue_k + 3'd1;
        end
        done <= pp_valid && pp_k == 2'd3;
        if (pp_valid && pp_k == 2'd3) begin
          run <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar   <= a;
      br   <= b;
      prod <= '0;
    end else if (run) begin
      pp   <= a_part * b_part;
      pp_k <= issue_k[1:0];
      if (pp_valid) begin
        prod <= prod + pp_shift;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/vdm_sqrt.sv
// ----------------------------------------------------------------------------
// vdm_sqrt
// Integer square root of a 128-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_sqrt
  import vdm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] v,
  output logic              done,
  output logic [63:0]       root
);

  logic [127:0] vr;
  logic [65:0]  rem;
  logic [5:0]   it;
  logic         run;
  logic [67:0]  rem_sh;
  logic [67:0]  trial;
  logic         take;

  assign rem_sh = {rem, vr[127:126]};
  assign trial  = {2'd0, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        run  <= 1'b1;
        done <= 1'b0;
      end else if (run && it == 6'd63) begin
        run  <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vr   <= v;
      rem  <= '0;
      root <= '0;
      it   <= '0;
    end else if (run) begin
      vr   <= {vr[125:0], 2'b00};
      it   <= it + 6'd1;
      rem  <= take ? 66'(rem_sh - trial) : rem_sh[65:0];
      root <= {root[62:0], take};
    end
  end

endmodule

`default_nettype wire

// File: rtl/vdm_div.sv
// ----------------------------------------------------------------------------
// vdm_div
// Restoring divider for (mag * 2^24) / den, one quotient bit per cycle,
// with a sticky flag for quotients that do not fit 48 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_div
  import vdm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [63:0]         mag,
  input  wire logic [63:0]         den,
  output logic                     done,
  output logic [METRIC_W-1:0]      q,
  output logic                     over
);

  localparam int NW = 64 + 24;
  localparam int IW = $clog2(NW);

  logic [NW-1:0] nd;
  logic [63:0]   dr;
  logic [63:0]   rem;
  logic [IW-1:0] it;
  logic          run;
  logic [64:0]   rs;
  logic          qb;

  assign rs = {rem, nd[NW-1]};
  assign qb = rs >= {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        run  <= 1'b1;
        done <= 1'b0;
      end else if (run && it == IW'(NW - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nd   <= {mag, 24'd0};
      dr   <= den;
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
      it   <= '0;
    end else if (run) begin
      nd   <= {nd[NW-2:0], 1'b0};
      rem  <= qb ? 64'(rs - {1'b0, dr}) : rs[63:0];
      over <= over | q[METRIC_W-1];
      q    <= {q[METRIC_W-2:0], qb};
      it   <= it + IW'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/vdm_back.sv
// ----------------------------------------------------------------------------
// vdm_back
// Metric sequencer: takes one vector's sums, runs the products, the root
// and the divide as the mode needs, and holds the result for the reader.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_back
  import vdm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output logic      res_valid,
  output out_item_t res,
  input  wire logic res_pop
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SQRT = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  job_t   jr;
  logic [2:0]   op;
  logic [63:0]  num;
  logic [63:0]  a_op;
  logic [63:0]  b_op;
  logic         neg;
  logic [METRIC_W-1:0] r_metric;
  logic [STATUS_W-1:0] r_status;

  logic         mul_start;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_done;
  logic [127:0] prod;
  logic         sqrt_start;
  logic [127:0] sqrt_v;
  logic         sqrt_done;
  logic [63:0]  root;
  logic         div_start;
  logic [63:0]  div_mag;
  logic         div_done;
  logic [METRIC_W-1:0] q;
  logic         over;
  logic         q_sat;

  logic         job_ratio;
  logic         mul_go;
  logic         sqrt_go;
  logic         div_go;
  logic         res_load;

  function automatic logic [METRIC_W-1:0] sat_pos(input logic [63:0] v);
    if (v[63:METRIC_W-1] != '0) return MET_MAX;
    return v[METRIC_W-1:0];
  endfunction

  vdm_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (prod)
  );

  vdm_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .v    (sqrt_v),
    .done (sqrt_done),
    .root (root)
  );

  vdm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .mag  (div_mag),
    .den  (root),
    .done (div_done),
    .q    (q),
    .over (over)
  );

  assign job_pop = (state == S_IDLE) && job_valid;
  assign q_sat   = over || q[METRIC_W-1];

  // start pulses for the shared units
  assign job_ratio = !job.too_long && (job.mode inside {MODE_PEARSON, MODE_COSINE});
  assign mul_go    = (job_pop && job_ratio) ||
                     ((state == S_MUL) && mul_done && op != 3'd6);
  assign sqrt_go   = (state == S_MUL) && mul_done && op == 3'd6;
  assign div_go    = (state == S_SQRT) && sqrt_done && root != '0;
  assign res_load  = (state == S_DONE) && (!res_valid || res_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mul_start  <= 1'b0;
      sqrt_start <= 1'b0;
      div_start  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      mul_start  <= mul_go;
      sqrt_start <= sqrt_go;
      div_start  <= div_go;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            jr <= job;
            if (job.too_long) begin
              r_metric <= '0;
              r_status <= ST_TOO_LONG;
              state    <= S_DONE;
            end else begin
              case (job.mode)
                MODE_EUCLID: begin
                  r_metric <= sat_pos(job.sd2);
                  r_status <= ST_OK;
                  state    <= S_DONE;
                end
                MODE_MANHATTAN: begin
                  r_metric <= sat_pos({job.sad[51:0], 12'd0});
                  r_status <= ST_OK;
                  state    <= S_DONE;
                end
                MODE_PEARSON: begin
                  op       <= 3'd0;
                  mul_a    <= 64'(job.n);
                  mul_b    <= job.sxy;
                  r_status <= ST_OK;
                  state    <= S_MUL;
                end
                MODE_COSINE: begin
                  op       <= 3'd6;
                  num      <= job.sxy;
                  mul_a    <= job.sx2;
                  mul_b    <= job.sy2;
                  r_status <= ST_OK;
                  state    <= S_MUL;
                end
                default: begin
                  r_metric <= '0;
                  r_status <= ST_BAD_MODE;
                  state    <= S_DONE;
                end
              endcase
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            op <= op + 3'd1;
            // numerator, then A, then B, then A*B for the root
            case (op)
              3'd0: begin
                num   <= prod[63:0];
                mul_a <= jr.sx;
                mul_b <= jr.sy;
              end
              3'd1: begin
                num   <= num - prod[63:0];
                mul_a <= 64'(jr.n);
                mul_b <= jr.sx2;
              end
              3'd2: begin
                a_op  <= prod[63:0];
                mul_a <= jr.sx;
                mul_b <= jr.sx;
              end
              3'd3: begin
                a_op  <= a_op - prod[63:0];
                mul_a <= 64'(jr.n);
                mul_b <= jr.sy2;
              end
              3'd4: begin
                b_op  <= prod[63:0];
                mul_a <= jr.sy;
                mul_b <= jr.sy;
              end
              3'd5: begin
                mul_a <= a_op;
                mul_b <= b_op - prod[63:0];
              end
              3'd6: begin
                sqrt_v <= prod;
                state  <= S_SQRT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (root == '0) begin
              r_metric <= '0;
              r_status <= ST_ZERO_DEN;
              state    <= S_DONE;
            end else begin
              neg     <= num[63];
              div_mag <= num[63] ? -num : num;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (neg) begin
              r_metric <= q_sat ? MET_MIN : -q;
            end else begin
              r_metric <= q_sat ? MET_MAX : q;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            res.metric <= r_metric;
            res.status <= r_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
